// File: rtl/core/qers_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qers_pkg
// Shared widths and constants of the encoder speed estimator.
// ----------------------------------------------------------------------------
package qers_pkg;
    localparam int CNT_W   = 32;
    localparam int SPD_W   = 24;
    localparam int PPR_W   = 16;
    localparam int DIV_W   = 48;
    localparam int NUM_W   = 66;
    localparam logic [SPD_W-1:0] SPEED_MAX = {SPD_W{1'b1}};
    localparam logic [31:0] USEC_PER_MIN = 32'd60000000;
    localparam logic [0:0] REG_PPR = 1'b0;

    typedef struct packed {
        logic start;
        logic sat;
    } t_lane_ctl;
endpackage

// File: rtl/core/qers_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qers_if
// Valid/ready channel carrying a payload of parameterized width.
// ----------------------------------------------------------------------------
interface qers_if #(parameter int W = 32);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/qers_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qers_lane
// One channel: restoring divider giving floor(delta*60e6*256/div), saturated.
// ----------------------------------------------------------------------------
module qers_lane (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  qers_pkg::t_lane_ctl     i_ctl,
    input  logic [31:0]             i_delta,
    input  logic [qers_pkg::DIV_W-1:0] i_div,
    output logic                    o_done,
    output logic [qers_pkg::SPD_W-1:0] o_speed
);
    import qers_pkg::*;

    localparam int STEPS = NUM_W;

    logic [63:0]      r_prod;
    logic [NUM_W-1:0] r_num;
    logic [DIV_W:0]   r_rem;
    logic [NUM_W-1:0] r_quo;
    logic [DIV_W-1:0] r_div;
    logic [6:0]       r_cnt;
    logic [1:0]       r_phase;
    logic             r_sat;
    logic             r_done;
    logic [DIV_W:0]   n_shift;
    logic [DIV_W:0]   n_sub;

    assign n_shift = {r_rem[DIV_W-1:0], r_num[NUM_W-1]};
    assign n_sub   = n_shift - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 2'd0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_prod  <= 64'(i_delta) * 64'(USEC_PER_MIN);
                r_div   <= i_div;
                r_sat   <= i_ctl.sat;
                r_phase <= 2'd1;
            end else if (r_phase == 2'd1) begin
                r_num   <= {r_prod, 2'b00} << 6;
                r_rem   <= '0;
                r_quo   <= '0;
                r_cnt   <= 7'(STEPS);
                r_phase <= 2'd2;
            end else if (r_phase == 2'd2) begin
                r_num <= r_num << 1;
                if (!n_sub[DIV_W]) begin
                    r_rem <= n_sub;
                    r_quo <= {r_quo[NUM_W-2:0], 1'b1};
                end else begin
                    r_rem <= n_shift;
                    r_quo <= {r_quo[NUM_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_phase <= 2'd0;
                    r_done  <= 1'b1;
                end
            end
        end
    end

    assign o_done  = r_done;
    // Any quotient bit above the field width means saturation.
    assign o_speed = (r_sat || (|r_quo[NUM_W-1:SPD_W])) ? SPEED_MAX : r_quo[SPD_W-1:0];
endmodule

// File: rtl/core/qers_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qers_merge
// Smoothing stage: new = floor((9*inst + old)/10) for every lane.
// ----------------------------------------------------------------------------
module qers_merge #(
    parameter int CHANNELS = 4
) (
    input  logic [CHANNELS-1:0][qers_pkg::SPD_W-1:0] i_inst,
    input  logic [CHANNELS-1:0][qers_pkg::SPD_W-1:0] i_old,
    output logic [CHANNELS-1:0][qers_pkg::SPD_W-1:0] o_new
);
    import qers_pkg::*;

    logic [CHANNELS-1:0][28:0] w_sum;
    logic [CHANNELS-1:0][63:0] w_q;

    // Divide by 10 through the reciprocal ceil(2^35/10), exact below 2^34.
    always_comb begin
        for (int i = 0; i < CHANNELS; i++) begin
            w_sum[i] = 29'(i_inst[i]) * 29'd9 + 29'(i_old[i]);
            w_q[i]   = (64'(w_sum[i]) * 64'd3435973837) >> 35;
            o_new[i] = w_q[i][SPD_W-1:0];
        end
    end
endmodule

// File: rtl/core/quad_encoder_rpm_estimator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_encoder_rpm_estimator
// Encoder speed estimation in Q.8 rpm with 0.9/0.1 exponential smoothing.
// ----------------------------------------------------------------------------
// After a transaction: product, 66-step divider, smoothing, then the result is registered valid.
// A new transaction is accepted only in idle, after the receiver has taken the previous result.
// All channels are divided at once, one lane per channel.
// A zero interval skips the dividers: the result is registered valid when the transaction is accepted.
// Synchronous active-low reset clears counts, time and speeds; pulses_per_rev=1.
module quad_encoder_rpm_estimator #(
    parameter int CHANNELS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    qers_if.sink        in_ch,
    qers_if.source      out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import qers_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_MERGE, S_OUT} t_state;

    t_state r_state;
    logic [PPR_W-1:0] r_ppr;
    logic [CHANNELS-1:0][CNT_W-1:0] r_prev;
    logic [CNT_W-1:0] r_ptime;
    logic [CHANNELS-1:0][SPD_W-1:0] r_spd;
    logic [CHANNELS-1:0][31:0] r_delta;
    logic [DIV_W-1:0] r_div;
    logic r_zero;
    logic r_start;
    logic r_oval;
    logic [CHANNELS-1:0] w_done;
    logic [CHANNELS-1:0][SPD_W-1:0] w_inst;
    logic [CHANNELS-1:0][SPD_W-1:0] w_new;
    logic [CNT_W-1:0] w_dt;
    t_lane_ctl w_ctl;

    assign pready = 1'b1;
    assign prdata = (paddr[1:0] == 2'b00) ? 32'(r_ppr) : 32'd0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppr <= PPR_W'(1);
        end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
            r_ppr <= pwdata[PPR_W-1:0];
        end
    end

    assign in_ch.ready = (r_state == S_IDLE);
    assign w_dt = in_ch.data[CHANNELS*CNT_W +: CNT_W] - r_ptime;
    assign w_ctl.start = r_start;
    assign w_ctl.sat   = (r_ppr == '0);

    for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
        qers_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_delta (r_delta[g]),
            .i_div   (r_div),
            .o_done  (w_done[g]),
            .o_speed (w_inst[g])
        );
    end

    qers_merge #(.CHANNELS(CHANNELS)) u_merge (
        .i_inst (w_inst),
        .i_old  (r_spd),
        .o_new  (w_new)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_prev  <= '0;
            r_ptime <= '0;
            r_spd   <= '0;
            r_start <= 1'b0;
            r_oval  <= 1'b0;
            r_zero  <= 1'b0;
        end else begin
            r_start <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (in_ch.valid) begin
                        for (int i = 0; i < CHANNELS; i++) begin
                            r_delta[i] <= in_ch.data[i*CNT_W +: CNT_W] - r_prev[i];
                            r_prev[i]  <= in_ch.data[i*CNT_W +: CNT_W];
                        end
                        r_ptime <= in_ch.data[CHANNELS*CNT_W +: CNT_W];
                        r_div   <= DIV_W'(w_dt) * DIV_W'(r_ppr);
                        r_zero  <= (w_dt == '0);
                        if (w_dt == '0) begin
                            r_state <= S_OUT;
                            r_oval  <= 1'b1;
                        end else begin
                            r_start <= 1'b1;
                            r_state <= S_RUN;
                        end
                    end
                end
                S_RUN: begin
                    if (w_done[0]) r_state <= S_MERGE;
                end
                S_MERGE: begin
                    r_spd   <= w_new;
                    r_oval  <= 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_ch.ready) begin
                        r_oval  <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign out_ch.valid = r_oval;
    always_comb begin
        for (int i = 0; i < CHANNELS; i++) out_ch.data[i*SPD_W +: SPD_W] = r_spd[i];
        out_ch.data[CHANNELS*SPD_W] = r_zero;
    end

`ifndef SYNTHESIS
    a_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oval |-> r_state == S_OUT) else $error("result valid outside output state");
    a_lanes_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done[0] |-> &w_done) else $error("lanes out of step");
    a_zero_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_zero) |-> $stable(r_spd)) else $error("speeds changed");
`endif
endmodule
